>>> src/apngbo_pkg.sv
// Shared constants and the pipeline type for the APNG over-blend pixel pipeline.
package apngbo_pkg;

   localparam int CH_COUNT  = 3;
   localparam int PIX_W     = 8;
   localparam int WEIGHT_W  = 16;
   localparam int ACC_W     = 24;
   localparam int DIV_STEPS = 8;

   localparam logic [PIX_W-1:0] FULL_ALPHA  = 8'd255;
   localparam logic [PIX_W-1:0] CLEAR_ALPHA = 8'd0;

   // al / 255 == (al * 32897) >> 23 for every al below 2^16
   localparam logic [16:0] DIV255_RECIP = 17'd32897;
   localparam int          DIV255_SHIFT = 23;

   localparam logic MODE_SOURCE = 1'b0;
   localparam logic MODE_OVER   = 1'b1;

   typedef struct packed {
      logic                                bypass;
      logic [CH_COUNT:0][PIX_W-1:0]        pix;
      logic [CH_COUNT-1:0][ACC_W-1:0]      acc;
      logic [WEIGHT_W-1:0]                 al;
      logic [PIX_W-1:0]                    alpha;
   } div_pipe_type;

endpackage

>>> src/apng_pixel_blend_over.sv
// Top level of the APNG pixel compositor: source copy or non-premultiplied over blend.
//
// Takes one source/destination pixel pair per cycle while req_stall is low and returns
// the composed pixel after one decode stage, one multiply stage, one sum stage, eight
// restoring-division stages (one quotient bit per stage for all three color
// channels in parallel) and an output register. The division chain sets the
// latency; throughput is one transaction per clock while the output is not stalled.
// The whole pipeline advances together whenever the output register is empty or being
// taken, so req_stall follows rsp_stall while the output holds a transaction.
// blend_mode is written through csr_wr_en/csr_wr_data and resets to source copy;
// change it only while no transaction is in flight.
module apng_pixel_blend_over
   import apngbo_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [PIX_W-1:0] req_src_ch0,
   input  logic [PIX_W-1:0] req_src_ch1,
   input  logic [PIX_W-1:0] req_src_ch2,
   input  logic [PIX_W-1:0] req_src_alpha,
   input  logic [PIX_W-1:0] req_dst_ch0,
   input  logic [PIX_W-1:0] req_dst_ch1,
   input  logic [PIX_W-1:0] req_dst_ch2,
   input  logic [PIX_W-1:0] req_dst_alpha,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_out_ch0,
   output logic [PIX_W-1:0] rsp_out_ch1,
   output logic [PIX_W-1:0] rsp_out_ch2,
   output logic [PIX_W-1:0] rsp_out_alpha
);

   logic advance;
   logic blend_mode_ff;

   // stage 1: weights and bypass decision
   logic                              s1_valid_ff;
   logic                              s1_bypass_ff, s1_bypass_in;
   logic [CH_COUNT:0][PIX_W-1:0]      s1_pix_ff, s1_pix_in;
   logic [WEIGHT_W-1:0]               s1_u_ff, s1_u_in;
   logic [WEIGHT_W-1:0]               s1_v_ff, s1_v_in;
   logic [CH_COUNT-1:0][PIX_W-1:0]    s1_src_ff, s1_dst_ff;

   // stage 2: weighted products
   logic                              s2_valid_ff;
   logic                              s2_bypass_ff;
   logic [CH_COUNT:0][PIX_W-1:0]      s2_pix_ff;
   logic [CH_COUNT-1:0][ACC_W-1:0]    s2_p_ff, s2_p_in;
   logic [CH_COUNT-1:0][ACC_W-1:0]    s2_q_ff, s2_q_in;
   logic [WEIGHT_W-1:0]               s2_al_ff, s2_al_in;

   // stage 3 feeds the division chain
   div_pipe_type                      s3_data_in;
   logic [32:0]                       alpha_prod;
   logic                              div_valid [0:DIV_STEPS];
   div_pipe_type                      div_data  [0:DIV_STEPS];

   // output register
   logic                              rsp_valid_ff;
   logic [CH_COUNT:0][PIX_W-1:0]      rsp_pix_ff, rsp_pix_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= MODE_SOURCE;
      end else if (csr_wr_en) begin
         blend_mode_ff <= csr_wr_data;
      end
   end

   always_comb begin
      logic src_copy;
      src_copy = (blend_mode_ff == MODE_SOURCE) || (req_src_alpha == FULL_ALPHA) ||
                 ((req_src_alpha != CLEAR_ALPHA) && (req_dst_alpha == CLEAR_ALPHA));
      s1_bypass_in = src_copy || (req_src_alpha == CLEAR_ALPHA);
      if (src_copy) begin
         s1_pix_in = {req_src_alpha, req_src_ch2, req_src_ch1, req_src_ch0};
      end else begin
         s1_pix_in = {req_dst_alpha, req_dst_ch2, req_dst_ch1, req_dst_ch0};
      end
      s1_u_in = {req_src_alpha, 8'd0} - {8'd0, req_src_alpha};
      s1_v_in = {8'd0, FULL_ALPHA - req_src_alpha} * {8'd0, req_dst_alpha};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_bypass_ff <= s1_bypass_in;
         s1_pix_ff    <= s1_pix_in;
         s1_u_ff      <= s1_u_in;
         s1_v_ff      <= s1_v_in;
         s1_src_ff    <= {req_src_ch2, req_src_ch1, req_src_ch0};
         s1_dst_ff    <= {req_dst_ch2, req_dst_ch1, req_dst_ch0};
      end
   end

   always_comb begin
      logic [WEIGHT_W:0] al_sum;
      for (int i = 0; i < CH_COUNT; i++) begin
         s2_p_in[i] = {16'd0, s1_src_ff[i]} * {8'd0, s1_u_ff};
         s2_q_in[i] = {16'd0, s1_dst_ff[i]} * {8'd0, s1_v_ff};
      end
      // u + v never exceeds 255 * 255
      al_sum   = {1'b0, s1_u_ff} + {1'b0, s1_v_ff};
      s2_al_in = al_sum[WEIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_bypass_ff <= s1_bypass_ff;
         s2_pix_ff    <= s1_pix_ff;
         s2_p_ff      <= s2_p_in;
         s2_q_ff      <= s2_q_in;
         s2_al_ff     <= s2_al_in;
      end
   end

   always_comb begin
      alpha_prod        = {17'd0, s2_al_ff} * {16'd0, DIV255_RECIP};
      s3_data_in.bypass = s2_bypass_ff;
      s3_data_in.pix    = s2_pix_ff;
      s3_data_in.al     = s2_al_ff;
      s3_data_in.alpha  = alpha_prod[DIV255_SHIFT+PIX_W-1:DIV255_SHIFT];
      // numerator stays below 256 * al, so the top bits start below the divisor
      for (int i = 0; i < CH_COUNT; i++) begin
         s3_data_in.acc[i] = s2_p_ff[i] + s2_q_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid[0] <= 1'b0;
      end else if (advance) begin
         div_valid[0] <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_data[0] <= s3_data_in;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      apngbo_div_step u_step (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .in_valid     (div_valid[k]),
         .in_data      (div_data[k]),
         .out_valid_ff (div_valid[k+1]),
         .out_data_ff  (div_data[k+1])
      );
   end

   always_comb begin
      if (div_data[DIV_STEPS].bypass) begin
         rsp_pix_in = div_data[DIV_STEPS].pix;
      end else begin
         rsp_pix_in = {div_data[DIV_STEPS].alpha,
                       div_data[DIV_STEPS].acc[2][PIX_W-1:0],
                       div_data[DIV_STEPS].acc[1][PIX_W-1:0],
                       div_data[DIV_STEPS].acc[0][PIX_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pix_ff <= rsp_pix_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_ch0   = rsp_pix_ff[0];
   assign rsp_out_ch1   = rsp_pix_ff[1];
   assign rsp_out_ch2   = rsp_pix_ff[2];
   assign rsp_out_alpha = rsp_pix_ff[3];

endmodule

>>> src/apngbo_div_step.sv
// One restoring-division step: one quotient bit for each color channel, registered.
module apngbo_div_step
   import apngbo_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  div_pipe_type in_data,
   output logic         out_valid_ff,
   output div_pipe_type out_data_ff
);

   div_pipe_type out_data_in;
   logic         out_valid_in;

   always_comb begin
      logic [WEIGHT_W:0] trial;
      logic [WEIGHT_W:0] diff;
      logic              ge;
      out_data_in  = in_data;
      out_valid_in = in_valid;
      // acc holds {remainder, numerator low bits shifting out, quotient bits shifting in}
      for (int i = 0; i < CH_COUNT; i++) begin
         trial = {in_data.acc[i][ACC_W-1:PIX_W], in_data.acc[i][PIX_W-1]};
         ge    = (trial >= {1'b0, in_data.al});
         diff  = trial - {1'b0, in_data.al};
         out_data_in.acc[i] = ge ?
            {diff[WEIGHT_W-1:0], in_data.acc[i][PIX_W-2:0], 1'b1} :
            {trial[WEIGHT_W-1:0], in_data.acc[i][PIX_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

>>> src/apngbo_checker.sv
// Port-level checks for the APNG over-blend pipeline, bound to the top level.
module apngbo_checker
   import apngbo_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             csr_wr_en,
   input logic             csr_wr_data,
   input logic             req_valid,
   input logic             req_stall,
   input logic [PIX_W-1:0] req_src_ch0,
   input logic [PIX_W-1:0] req_src_ch1,
   input logic [PIX_W-1:0] req_src_ch2,
   input logic [PIX_W-1:0] req_src_alpha,
   input logic [PIX_W-1:0] req_dst_ch0,
   input logic [PIX_W-1:0] req_dst_ch1,
   input logic [PIX_W-1:0] req_dst_ch2,
   input logic [PIX_W-1:0] req_dst_alpha,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [PIX_W-1:0] rsp_out_ch0,
   input logic [PIX_W-1:0] rsp_out_ch1,
   input logic [PIX_W-1:0] rsp_out_ch2,
   input logic [PIX_W-1:0] rsp_out_alpha
);

   // hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_ch0) &&
         $stable(rsp_out_ch1) && $stable(rsp_out_ch2) && $stable(rsp_out_alpha))
      else $error("stalled response changed");

   // a blocked output freezes the whole pipeline, input included
   a_block_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");

   // an open output never pushes back on the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled with output open");

   // pipeline drains on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind apng_pixel_blend_over apngbo_checker u_checker (.*);
